/* hw/rtl/tilt_posture_detector_top_defines.svh */
// ----------------------------------------------------------------------------
// Tilt posture detector assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TILT_POSTURE_DETECTOR_TOP_DEFINES_SVH
`define TILT_POSTURE_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TPD_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// Tilt posture detector package
// Field widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

  localparam int Z_W            = 16;
  localparam int ONE_G_W        = 15;
  localparam int LEVEL_W        = 16;
  localparam int WINDOW_LEN_DEF = 20;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ONE_G_W-1:0]        ONE_G_RST = 15'd17694;
  localparam logic signed [LEVEL_W-1:0] ENTER_RST = 16'sd12512;
  localparam logic signed [LEVEL_W-1:0] LEAVE_RST = 16'sd15323;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONE_G = 2'd0,
    REG_ENTER = 2'd1,
    REG_LEAVE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ONE_G_W-1:0]        one_g;
    logic signed [LEVEL_W-1:0] enter_lvl;
    logic signed [LEVEL_W-1:0] leave_lvl;
  } tpd_cfg_t;

  typedef struct packed {
    logic                  vld;
    logic signed [Z_W-1:0] mean;
  } mean_stage_t;

endpackage

`default_nettype wire

/* hw/rtl/tpd_window.sv */
// ----------------------------------------------------------------------------
// Sample window
// Shift line of the last samples and the running sum of the line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpd_window
  import tpd_pkg::*;
#(
  parameter int  WindowLen = WINDOW_LEN_DEF,
  localparam int SumW      = Z_W + $clog2(WindowLen)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   load_en,
  input  wire logic signed [Z_W-1:0]  z_sample,
  output logic                        sum_vld,
  output logic signed [SumW-1:0]      win_sum
);

  logic signed [Z_W-1:0]  tap_r [WindowLen];
  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] sum_nxt;
  logic                   vld_r;
  logic                   accept;

  assign accept = in_valid & load_en;

  // The oldest sample leaves the window as the new one enters.
  assign sum_nxt = sum_r + SumW'(z_sample) - SumW'(tap_r[WindowLen-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WindowLen; i++) begin
        tap_r[i] <= '0;
      end
      sum_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (load_en) begin
        vld_r <= in_valid;
      end
      if (accept) begin
        tap_r[0] <= z_sample;
        for (int i = 1; i < WindowLen; i++) begin
          tap_r[i] <= tap_r[i-1];
        end
        sum_r <= sum_nxt;
      end
    end
  end

  assign sum_vld = vld_r;
  assign win_sum = sum_r;

endmodule

`default_nettype wire

/* hw/rtl/tpd_mean.sv */
// ----------------------------------------------------------------------------
// Window mean
// Floor mean of the window sum by reciprocal multiply, clamped to one g.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpd_mean
  import tpd_pkg::*;
#(
  parameter int  WindowLen = WINDOW_LEN_DEF,
  localparam int SumW      = Z_W + $clog2(WindowLen)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load_en,
  input  wire logic                   src_vld,
  input  wire logic signed [SumW-1:0] win_sum,
  input  wire logic [ONE_G_W-1:0]     one_g,
  output mean_stage_t                 stage
);

  localparam int LenLog = $clog2(WindowLen);
  localparam int Shift  = SumW + LenLog;
  localparam int RecipW = SumW + 1;
  localparam int ProdW  = SumW + RecipW;

  // Biasing by half the sample range times the length makes the sum
  // nonnegative, so an unsigned exact reciprocal gives the floor quotient.
  localparam logic [SumW-1:0]   Bias  = SumW'(longint'(WindowLen) << (Z_W - 1));
  localparam logic [RecipW-1:0] Recip = RecipW'(((64'd1 << Shift) / WindowLen) + 1);

  logic [SumW-1:0]        sum_biased;
  logic [ProdW-1:0]       prod;
  logic [Z_W-1:0]         quo;
  logic signed [Z_W-1:0]  mean_raw;
  logic signed [Z_W-1:0]  ceil_val;
  logic signed [Z_W-1:0]  mean_clamped;
  mean_stage_t            stage_r;

  assign sum_biased = $unsigned(win_sum) + Bias;
  assign prod       = ProdW'(sum_biased) * ProdW'(Recip);
  assign quo        = prod[Shift +: Z_W];

  // Removing the bias flips the top bit of the 16-bit quotient.
  assign mean_raw     = $signed({~quo[Z_W-1], quo[Z_W-2:0]});
  assign ceil_val     = $signed({1'b0, one_g});
  assign mean_clamped = (mean_raw > ceil_val) ? ceil_val : mean_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (load_en) begin
      stage_r.vld  <= src_vld;
      stage_r.mean <= mean_clamped;
    end
  end

  assign stage = stage_r;

endmodule

`default_nettype wire

/* hw/rtl/tpd_hyst.sv */
// ----------------------------------------------------------------------------
// Posture hysteresis
// Two-level posture switch on the mean and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpd_hyst
  import tpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load_en,
  input  wire mean_stage_t           src,
  input  wire tpd_cfg_t              cfg,
  output logic                       out_vld,
  output logic signed [Z_W-1:0]      filtered_z,
  output logic                       upright,
  output logic                       led_drive
);

  logic                  posture_r;
  logic                  posture_nxt;
  logic                  out_vld_r;
  logic signed [Z_W-1:0] fz_r;
  logic                  upright_r;
  logic                  led_r;
  logic signed [Z_W:0]   mean_ext;
  logic signed [Z_W:0]   neg_one_g;
  logic                  in_range;

  assign mean_ext  = $signed({src.mean[Z_W-1], src.mean});
  assign neg_one_g = -$signed({2'b00, cfg.one_g});
  // Below minus one g the tilt angle is undefined and the posture holds.
  assign in_range  = (mean_ext >= neg_one_g);

  always_comb begin
    posture_nxt = posture_r;
    if (in_range) begin
      if (!posture_r) begin
        if (src.mean < cfg.enter_lvl) begin
          posture_nxt = 1'b1;
        end
      end else begin
        if (src.mean > cfg.leave_lvl) begin
          posture_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      posture_r <= 1'b0;
    end else if (load_en) begin
      out_vld_r <= src.vld;
      if (src.vld) begin
        posture_r <= posture_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && src.vld) begin
      fz_r      <= src.mean;
      upright_r <= posture_nxt;
      led_r     <= posture_r;
    end
  end

  assign out_vld    = out_vld_r;
  assign filtered_z = fz_r;
  assign upright    = upright_r;
  assign led_drive  = led_r;

endmodule

`default_nettype wire

/* hw/rtl/tilt_posture_detector_top.sv */
// ----------------------------------------------------------------------------
// Tilt posture detector
// Moving average of a z-axis accelerometer stream with a hysteresis switch.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Width | Contents (lowest bit first)
//   in_     | slave     | 16    | z_sample[15:0]
//   out_    | master    | 24    | filtered_z[15:0], upright, led_drive, zero pad
//   cfg_    | write     | 16    | index 0 one_g_count, 1 enter, 2 leave
//
// The block takes one word per clock cycle while in_tready is high, and gives
// one result word for each input word after it has passed three register
// stages: the window sum, the reciprocal multiply that forms the mean, and
// the posture register.
// Reset is synchronous and active low; it clears the window, the sum,
// the posture and the configuration registers to their defaults.
// Each stage moves when the stage after it is empty or moving, so a stalled
// output still lets empty stages fill before in_tready drops.
//
`timescale 1ns / 1ps
`default_nettype none

module tilt_posture_detector_top
  import tpd_pkg::*;
#(
  parameter int WindowLen = WINDOW_LEN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // z_sample[15:0]
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // filtered_z[15:0], upright[16],
                                                  // led_drive[17], zeros[23:18]
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SumW = Z_W + $clog2(WindowLen);

  tpd_cfg_t               cfg_r;
  logic                   en_win;
  logic                   en_mean;
  logic                   en_out;
  logic                   sum_vld;
  logic signed [SumW-1:0] win_sum;
  mean_stage_t            mean_stage;
  logic                   out_vld;
  logic signed [Z_W-1:0]  filtered_z;
  logic                   upright;
  logic                   led_drive;

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_g     <= ONE_G_RST;
      cfg_r.enter_lvl <= ENTER_RST;
      cfg_r.leave_lvl <= LEAVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONE_G: cfg_r.one_g     <= cfg_wdata[ONE_G_W-1:0];
        REG_ENTER: cfg_r.enter_lvl <= $signed(cfg_wdata[LEVEL_W-1:0]);
        REG_LEAVE: cfg_r.leave_lvl <= $signed(cfg_wdata[LEVEL_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its contents move on.
  assign en_out  = ~out_vld | out_tready;
  assign en_mean = ~mean_stage.vld | en_out;
  assign en_win  = ~sum_vld | en_mean;

  assign in_tready = en_win;

  tpd_window #(
    .WindowLen (WindowLen)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .load_en  (en_win),
    .z_sample ($signed(in_tdata[Z_W-1:0])),
    .sum_vld  (sum_vld),
    .win_sum  (win_sum)
  );

  tpd_mean #(
    .WindowLen (WindowLen)
  ) u_mean (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_en (en_mean),
    .src_vld (sum_vld),
    .win_sum (win_sum),
    .one_g   (cfg_r.one_g),
    .stage   (mean_stage)
  );

  tpd_hyst u_hyst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (en_out),
    .src        (mean_stage),
    .cfg        (cfg_r),
    .out_vld    (out_vld),
    .filtered_z (filtered_z),
    .upright    (upright),
    .led_drive  (led_drive)
  );

  assign out_tvalid = out_vld;
  assign out_tdata  = {{(OUT_TDATA_W - Z_W - 2){1'b0}}, led_drive, upright,
                       filtered_z};

endmodule

`default_nettype wire

/* hw/rtl/tpd_checker.sv */
// ----------------------------------------------------------------------------
// Tilt posture detector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tilt_posture_detector_top_defines.svh"

module tpd_checker
  import tpd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic last_up_r;

  // Posture reported by the last delivered word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_up_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_up_r <= out_tdata[Z_W];
    end
  end

  `TPD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")
  `TPD_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "result valid right after reset")
  `TPD_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "input stalled with empty output")
  `TPD_ASSERT_NOW(a_led_chain, out_tvalid, out_tdata[Z_W+1] == last_up_r, "led_drive does not match previous posture")

endmodule

bind tilt_posture_detector_top tpd_checker u_tpd_checker (.*);

`default_nettype wire

/* verif/posture_checker.sv */
// ----------------------------------------------------------------------------
// Tilt posture detector result checker
// Watches the input, result and configuration ports of the detector, keeps
// its own copy of the sample window, the running sum, the posture and the
// registers, and compares every result word against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module posture_checker
  import tpd_pkg::*;
#(
  parameter int WindowLen = WINDOW_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // z_sample[15:0]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // filtered_z[15:0], upright, led_drive
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     words_pending
);

  // Lowest bits first: filtered_z, then upright, then led_drive.
  typedef struct packed {
    logic                  led_drive;
    logic                  upright;
    logic signed [Z_W-1:0] filtered_z;
  } posture_word_t;

  tpd_cfg_t              cfg;
  logic signed [Z_W-1:0] z_ring [WindowLen];
  int                    ring_slot;
  int                    ring_total;
  logic                  posture;
  posture_word_t         expected_words [$];

  // Moves one sample into the window and returns the word it should produce.
  function automatic posture_word_t advance_window(logic signed [Z_W-1:0] z);
    posture_word_t w;
    int            mean;
    int            ceiling;
    ceiling    = int'(cfg.one_g);
    ring_total = ring_total - z_ring[ring_slot] + z;
    z_ring[ring_slot] = z;
    ring_slot  = (ring_slot + 1) % WindowLen;
    // Floor division, rounding toward minus infinity for negative sums.
    if (ring_total >= 0) begin
      mean = ring_total / WindowLen;
    end else begin
      mean = -((WindowLen - 1 - ring_total) / WindowLen);
    end
    if (mean > ceiling) begin
      mean = ceiling;
    end
    w.led_drive = posture;
    // Below minus one g the tilt angle is undefined, so the posture holds.
    if (mean >= -ceiling) begin
      if (!posture && mean < cfg.enter_lvl) begin
        posture = 1'b1;
      end else if (posture && mean > cfg.leave_lvl) begin
        posture = 1'b0;
      end
    end
    w.upright    = posture;
    w.filtered_z = Z_W'(mean);
    return w;
  endfunction

  always @(posedge clk) begin : track
    posture_word_t got;
    posture_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < WindowLen; i++) begin
        z_ring[i] = '0;
      end
      ring_slot  = 0;
      ring_total = 0;
      posture    = 1'b0;
      cfg        = '{one_g: ONE_G_RST, enter_lvl: ENTER_RST, leave_lvl: LEAVE_RST};
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ONE_G: cfg.one_g     = cfg_wdata[ONE_G_W-1:0];
          REG_ENTER: cfg.enter_lvl = cfg_wdata[LEVEL_W-1:0];
          REG_LEAVE: cfg.leave_lvl = cfg_wdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(posture_word_t)-1:0];
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result word %h arrived with nothing pending", out_tdata);
          end
        end else begin
          want = expected_words.pop_front();
          if (got.filtered_z !== want.filtered_z || got.upright !== want.upright ||
              got.led_drive !== want.led_drive) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: filtered_z exp %0d got %0d, upright exp %0b got %0b, %s",
                       want.filtered_z, got.filtered_z, want.upright, got.upright,
                       $sformatf("led_drive exp %0b got %0b", want.led_drive, got.led_drive));
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_words.push_back(advance_window(in_tdata));
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Tilt posture detector testbench
// Drives accelerometer samples into the detector under several register
// settings, with random gaps on the input and random stalls on the output,
// and leaves prediction and comparison to the result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tpd_pkg::*;

  // Three register stages sit between an accepted sample and its result.
  localparam int PIPE_LATENCY = 3;
  // The slowest correct run goes quiet for at most a long output stall plus
  // the pipeline, or a long input gap plus a settle pause, so a far longer
  // stretch without any handshake can only mean a hang.
  localparam int STALL_LIMIT = 5000;

  // Short hand-picked sequence, run under a small ceiling and narrow levels
  // so that clamping, both posture switches, the hold below minus one g and
  // floor rounding of negative sums all show up within a few words.
  localparam logic [Z_W-1:0] PROBE_WORDS [22] = '{
    16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'h7530, 16'h03E8, 16'h07D0, 16'h03E8,
    16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFCE, 16'hFFCE, 16'h0032,
    16'h0033, 16'h0064, 16'hFF9C, 16'h8000, 16'h7FFF, 16'h0000
  };

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int fail_count;
  int words_pending;
  int idle_cycles;

  // When set, neither side inserts gaps, giving stretches at full rate.
  bit steady_flow;

  // Copy of the register values, used only to aim the stimulus.
  int cur_one_g = ONE_G_RST;
  int cur_enter = ENTER_RST;
  int cur_leave = LEAVE_RST;

  tilt_posture_detector_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  posture_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap lengths shared by both sides: mostly none, often short ones,
  // now and then a long one.
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady_flow || pick < 65) begin
      return 0;
    end else if (pick < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [Z_W-1:0] clip16(int v);
    if (v > 32767) begin
      return 16'h7FFF;
    end else if (v < -32768) begin
      return 16'h8000;
    end
    return Z_W'(v);
  endfunction

  // Aim a run of samples at a point of interest for the current registers:
  // near either level, near plus or minus one g, near zero, at random, or at the rails.
  function automatic int pick_center();
    int off;
    off = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 7))
      0: return cur_enter + off;
      1: return cur_leave + off;
      2: return cur_one_g + off;
      3: return -cur_one_g + off;
      4: return off;
      5: return int'($urandom_range(0, 65535)) - 32768;
      6: return 32767 + off;
      default: return -32768 + off;
    endcase
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 3;
      2: return 60;
      3: return 1500;
      default: return 20000;
    endcase
  endfunction

  // Output side: ready for a random number of cycles, then a stall whose
  // length follows the shared gap profile.
  initial begin : sink_stalls
    int stall;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = gap_cycles();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Presents one word and returns at the edge that accepts it. The valid
  // stays high afterward so back-to-back words need no second assignment.
  task automatic send_word(logic [Z_W-1:0] z);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= z;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Holds the input off until every predicted word has come back, then
  // lets the pipeline settle. The first edge lets the checker count the
  // word that was accepted at the current one.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called while idle.
  task automatic write_regs(logic [CFG_DATA_W-1:0] g_word, logic [CFG_DATA_W-1:0] enter_word,
                            logic [CFG_DATA_W-1:0] leave_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ONE_G;
    cfg_wdata <= g_word;
    @(posedge clk);
    cfg_index <= REG_ENTER;
    cfg_wdata <= enter_word;
    @(posedge clk);
    cfg_index <= REG_LEAVE;
    cfg_wdata <= leave_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_one_g = int'(g_word[ONE_G_W-1:0]);
    cur_enter = int'($signed(enter_word));
    cur_leave = int'($signed(leave_word));
  endtask

  // Register settings per phase: the extremes first, then the reset values with a stray top bit, then random ones.
  task automatic apply_setting(int phase);
    int g;
    int lo;
    case (phase)
      0: write_regs(16'h7FFF, 16'h7FFF, 16'h8000);
      1: write_regs(16'h7FFF, 16'h8000, 16'h7FFF);
      2: write_regs(16'd1, 16'd0, 16'd0);
      3: write_regs(16'd1, 16'h8000, 16'h7FFF);
      // The top bit of the one-g word lies above the register and must not stick.
      4: write_regs(16'h8000 | 16'd17694, 16'd12512, 16'd15323);
      default: begin
        g = $urandom_range(1, 32767);
        if ($urandom_range(0, 1) == 0) begin
          // Ordered levels, the enter level below the ceiling, as a real sensor setup would have.
          lo = $urandom_range(0, g);
          write_regs(CFG_DATA_W'(g), clip16(lo), clip16(lo + int'($urandom_range(0, g))));
        end else begin
          write_regs(CFG_DATA_W'(g), CFG_DATA_W'($urandom_range(0, 65535)),
                     CFG_DATA_W'($urandom_range(0, 65535)));
        end
      end
    endcase
  endtask

  // Random traffic: mostly runs of samples clustered around a point of
  // interest, so the window mean lingers there long enough to trip the
  // switches, with short bursts of raw noise in between.
  task automatic random_traffic(int n_items);
    int sent;
    int seg_len;
    int center;
    int amp;
    sent = 0;
    while (sent < n_items) begin
      steady_flow = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        seg_len = $urandom_range(1, 8);
        for (int k = 0; k < seg_len; k++) begin
          send_word(Z_W'($urandom_range(0, 65535)));
        end
      end else begin
        center  = pick_center();
        amp     = pick_spread();
        seg_len = $urandom_range(12, 60);
        for (int k = 0; k < seg_len; k++) begin
          if (amp == 0) begin
            send_word(clip16(center));
          end else begin
            send_word(clip16(center + int'($urandom_range(0, 2 * amp)) - amp));
          end
        end
      end
      sent += seg_len;
      if ($urandom_range(0, 11) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of the registers, untouched. The drain in the middle
    // makes sure the sender waits out the whole pipeline at least once.
    random_traffic(110);
    wait_drained();
    random_traffic(110);
    wait_drained();

    // Directed words under a tiny ceiling and narrow hysteresis band.
    write_regs(16'd100, 16'hFFCE, 16'h0032);
    steady_flow = 1'b0;
    foreach (PROBE_WORDS[i]) begin
      send_word(PROBE_WORDS[i]);
    end
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      apply_setting(phase);
      random_traffic(190);
      wait_drained();
    end

    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_window.sv
hw/rtl/tpd_mean.sv
hw/rtl/tpd_hyst.sv
hw/rtl/tilt_posture_detector_top.sv
hw/rtl/tpd_checker.sv
verif/posture_checker.sv
verif/tb.sv
